### design/asod_pkg.sv
package asod_pkg;

  localparam int ACC_W     = 19;
  localparam int DELTA_W   = 20;
  localparam int TIME_W    = 40;
  localparam int MEAN_W    = 36;
  localparam int DISP_W    = 40;
  localparam int CNT_W     = 11;
  localparam int W_W       = 17;
  localparam int AXIS_W    = 2;
  localparam int STEP_W    = 4;
  localparam int DIV_STEPS = 2;
  localparam int CFG_IDX_W = 3;

  localparam int EMA_TIME_US_DEF    = 500000;
  localparam int OVERTIME_LIMIT_DEF = 1000;

  localparam logic [CFG_IDX_W-1:0] REG_LENIENT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_THRESH  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TOL     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GRAVITY = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT = 3'd4;

  localparam logic [15:0]       THRESH_RST  = 16'd256;
  localparam logic [15:0]       TOL_RST     = 16'd5120;
  localparam logic [15:0]       GRAVITY_RST = 16'd10042;
  localparam logic [TIME_W-1:0] TIMEOUT_RST = 40'd90000000;

  localparam logic [TIME_W-1:0] STILL_TIME_NORMAL  = 40'd1300000;
  localparam logic [TIME_W-1:0] STILL_TIME_LENIENT = 40'd500000;

  localparam logic [1:0] STAT_MOVING  = 2'd0;
  localparam logic [1:0] STAT_STILL   = 2'd1;
  localparam logic [1:0] STAT_DECIDED = 2'd2;
  localparam logic [1:0] STAT_TIMEOUT = 2'd3;

  localparam logic [2:0] OR_POS_X = 3'd0;
  localparam logic [2:0] OR_NEG_X = 3'd1;
  localparam logic [2:0] OR_POS_Y = 3'd2;
  localparam logic [2:0] OR_NEG_Y = 3'd3;
  localparam logic [2:0] OR_POS_Z = 3'd4;
  localparam logic [2:0] OR_NEG_Z = 3'd5;
  localparam logic [2:0] OR_NONE  = 3'd6;

  typedef struct packed {
    logic              accept;
    logic              div_step;
    logic              ph_a;
    logic              ph_b;
    logic              ph_c;
    logic [AXIS_W-1:0] axis;
    logic              decide;
  } asod_cmd_t;

  typedef struct packed {
    logic out_busy;
  } asod_stat_t;

endpackage

### design/asod_if.sv
interface asod_in_if;
  import asod_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [ACC_W-1:0]   accel_x;
  logic signed [ACC_W-1:0]   accel_y;
  logic signed [ACC_W-1:0]   accel_z;
  logic        [DELTA_W-1:0] delta_us;
  modport source (output valid, accel_x, accel_y, accel_z, delta_us, input ready);
  modport sink (input valid, accel_x, accel_y, accel_z, delta_us, output ready);
endinterface

interface asod_out_if;
  import asod_pkg::*;
  logic                    valid;
  logic                    ready;
  logic        [1:0]       status;
  logic        [2:0]       orientation;
  logic signed [ACC_W-1:0] mean_x;
  logic signed [ACC_W-1:0] mean_y;
  logic signed [ACC_W-1:0] mean_z;
  modport source (output valid, status, orientation, mean_x, mean_y, mean_z, input ready);
  modport sink (input valid, status, orientation, mean_x, mean_y, mean_z, output ready);
endinterface

interface asod_cfg_if;
  import asod_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [TIME_W-1:0]    data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### design/accel_still_orientation_detect_core.sv
// channel | dir | beat payload
// in_ch   | in  | accel_x, accel_y, accel_z, delta_us
// out_ch  | out | status, orientation, mean_x, mean_y, mean_z
// cfg_ch  | in  | index, data (always ready)
//
// after accept, a sample goes through the reciprocal weight multiply steps, then phases a, b
// and c for each axis through one shared multiply stage, then the decide step
// the next sample is accepted while a result waits in the output register
// the decide cycle waits while the output register is full and not taken
// rst_n is synchronous, active low; no clearing pass
module accel_still_orientation_detect_core
  import asod_pkg::*;
#(
  parameter int EMA_TIME_US    = EMA_TIME_US_DEF,
  parameter int OVERTIME_LIMIT = OVERTIME_LIMIT_DEF
) (
  input logic         clk,
  input logic         rst_n,
  asod_in_if.sink     in_ch,
  asod_out_if.source  out_ch,
  asod_cfg_if.sink    cfg_ch
);

  asod_cmd_t  cmd;
  asod_stat_t stat;

  assign cfg_ch.ready = 1'b1;

  asod_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  asod_dp #(
    .EMA_TIME_US    (EMA_TIME_US),
    .OVERTIME_LIMIT (OVERTIME_LIMIT)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .in_accel_x      (in_ch.accel_x),
    .in_accel_y      (in_ch.accel_y),
    .in_accel_z      (in_ch.accel_z),
    .in_delta_us     (in_ch.delta_us),
    .cfg_we          (cfg_ch.valid),
    .cfg_index       (cfg_ch.index),
    .cfg_data        (cfg_ch.data),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .out_status      (out_ch.status),
    .out_orientation (out_ch.orientation),
    .out_mean_x      (out_ch.mean_x),
    .out_mean_y      (out_ch.mean_y),
    .out_mean_z      (out_ch.mean_z)
  );

endmodule

### design/asod_ctrl.sv
module asod_ctrl
  import asod_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  asod_stat_t stat,
  output asod_cmd_t  cmd
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_DIV    = 3'd1;
  localparam logic [2:0] ST_AXA    = 3'd2;
  localparam logic [2:0] ST_AXB    = 3'd3;
  localparam logic [2:0] ST_AXC    = 3'd4;
  localparam logic [2:0] ST_DECIDE = 3'd5;

  logic [2:0]        state_r, state_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [AXIS_W-1:0] axis_r, axis_nxt;

  assign in_ready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt    = state_r;
    step_nxt     = step_r;
    axis_nxt     = axis_r;
    cmd          = '0;
    cmd.axis     = axis_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          step_nxt   = '0;
          state_nxt  = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        step_nxt     = step_r + 1'b1;
        if (step_r == STEP_W'(DIV_STEPS - 1)) begin
          axis_nxt  = '0;
          state_nxt = ST_AXA;
        end
      end
      ST_AXA: begin
        cmd.ph_a  = 1'b1;
        state_nxt = ST_AXB;
      end
      ST_AXB: begin
        cmd.ph_b  = 1'b1;
        state_nxt = ST_AXC;
      end
      ST_AXC: begin
        cmd.ph_c = 1'b1;
        if (axis_r == AXIS_W'(2)) begin
          state_nxt = ST_DECIDE;
        end else begin
          axis_nxt  = axis_r + 1'b1;
          state_nxt = ST_AXA;
        end
      end
      ST_DECIDE: begin
        if (!stat.out_busy) begin
          cmd.decide = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r  <= '0;
      axis_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      axis_r  <= axis_nxt;
    end
  end

  a_accept_div: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.accept |=> state_r == ST_DIV)
    else $error("accept not followed by divide");
  a_axis_range: assert property (@(posedge clk) disable iff (!rst_n)
    axis_r != AXIS_W'(3))
    else $error("axis index out of range");
  a_decide_once: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.decide |=> !cmd.decide && in_ready)
    else $error("decide not followed by idle");

endmodule

### design/asod_dp.sv
module asod_dp
  import asod_pkg::*;
#(
  parameter int EMA_TIME_US    = EMA_TIME_US_DEF,
  parameter int OVERTIME_LIMIT = OVERTIME_LIMIT_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  asod_cmd_t                 cmd,
  output asod_stat_t                stat,
  input  logic signed [ACC_W-1:0]   in_accel_x,
  input  logic signed [ACC_W-1:0]   in_accel_y,
  input  logic signed [ACC_W-1:0]   in_accel_z,
  input  logic        [DELTA_W-1:0] in_delta_us,
  input  logic                      cfg_we,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [TIME_W-1:0]         cfg_data,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic        [1:0]         out_status,
  output logic        [2:0]         out_orientation,
  output logic signed [ACC_W-1:0]   out_mean_x,
  output logic signed [ACC_W-1:0]   out_mean_y,
  output logic signed [ACC_W-1:0]   out_mean_z
);

  // weight by reciprocal: floor(delta * RCP_K / 2^47), exact while delta < EMA_TIME_US
  localparam int RCP_SH = 63;
  localparam logic [63:0] RCP_K =
    ((64'd1 << RCP_SH) + 64'(EMA_TIME_US) - 64'd1) / 64'(EMA_TIME_US);
  localparam logic [26:0] RCP_LO = RCP_K[26:0];
  localparam logic [26:0] RCP_HI = RCP_K[53:27];
  localparam logic [W_W-1:0]    W_ONE   = 17'h10000;
  localparam logic [TIME_W:0]   T_MAX   = {1'b0, {TIME_W{1'b1}}};
  localparam logic [CNT_W:0]    OT_LIM  = (CNT_W+1)'(OVERTIME_LIMIT);

  // config
  logic              lenient_r;
  logic [15:0]       thresh_r, tol_r, grav_r;
  logic [TIME_W-1:0] timeout_r;

  // run state
  logic signed [MEAN_W-1:0] mean_r [3];
  logic        [DISP_W-1:0] disp_r [3];
  logic [TIME_W-1:0]        elapsed_r, still_start_r, deadline_r;
  logic                     still_r;
  logic [CNT_W-1:0]         ot_cnt_r;

  // per item
  logic signed [ACC_W-1:0] smp_r [3];
  logic [DELTA_W-1:0]      dlt_r;
  logic [46:0]             plo_r, phi_r;
  logic [15:0]             q_r;
  logic                    wsat_r;
  logic [35:0]             thr2_r;
  logic signed [36:0]      d_r;
  logic signed [54:0]      mw_r;
  logic [41:0]             sq_r;
  logic [56:0]             dd_r;
  logic                    all_below_r, any_above_r;
  logic [2:0]              nz_r, np_r, nn_r;

  // output
  logic                    out_valid_r;
  logic [1:0]              out_status_r;
  logic [2:0]              out_orient_r;
  logic signed [ACC_W-1:0] out_mean_r [3];

  logic [W_W-1:0]     w;
  logic [17:0]        thr;
  logic [73:0]        wsum;
  logic [TIME_W:0]    elapsed_sum;
  logic signed [36:0] d_nxt;
  logic signed [20:0] e;
  logic signed [MEAN_W-1:0] mean_new;
  logic [DISP_W-1:0]  disp_dec, disp_new;
  logic [38:0]        thr8, sq_c;
  logic signed [37:0] mq, gq, tq;
  logic [2:0]         orient;
  logic               fin_still, fin_to, fin, still_new, past_dl;
  logic [TIME_W-1:0]  deadline_new, restart_dl, start_new;
  logic [TIME_W:0]    dl_sum, still_end;
  logic [CNT_W:0]     ot_next;
  logic [CNT_W-1:0]   ot_new;
  logic [1:0]         status;

  function automatic logic near_tol(input logic signed [37:0] v,
                                    input logic signed [37:0] t);
    near_tol = (v < t) && (v > -t);
  endfunction

  assign w    = wsat_r ? W_ONE : {1'b0, q_r};
  assign thr  = lenient_r ? (18'(thresh_r) + {1'b0, thresh_r, 1'b0}) : 18'(thresh_r);
  assign wsum = {phi_r, 27'd0} + 74'(plo_r);
  assign elapsed_sum = {1'b0, elapsed_r} + (TIME_W+1)'(in_delta_us);

  // axis phase a
  always_comb begin
    logic signed [ACC_W-1:0] x;
    x = smp_r[cmd.axis];
    d_nxt = 37'($signed({x, 16'h0000})) - 37'(mean_r[cmd.axis]);
  end

  assign e = d_r[36:16];

  // axis phase c
  assign mean_new = mean_r[cmd.axis] + MEAN_W'(mw_r >>> 16);
  assign disp_dec = dd_r[55:16];
  assign thr8     = {thr2_r, 3'b000};
  assign sq_c     = (sq_r > 42'(thr8)) ? thr8 : sq_r[38:0];
  assign disp_new = (40'(sq_c) > disp_dec) ? 40'(sq_c) : disp_dec;
  assign mq = 38'(mean_new);
  assign gq = $signed({6'b0, grav_r, 16'h0000});
  assign tq = $signed({6'b0, tol_r, 16'h0000});

  // decision
  always_comb begin
    if (np_r[0] && nz_r[1] && nz_r[2])      orient = OR_POS_X;
    else if (nn_r[0] && nz_r[1] && nz_r[2]) orient = OR_NEG_X;
    else if (nz_r[0] && np_r[1] && nz_r[2]) orient = OR_POS_Y;
    else if (nz_r[0] && nn_r[1] && nz_r[2]) orient = OR_NEG_Y;
    else if (nz_r[0] && nz_r[1] && np_r[2]) orient = OR_POS_Z;
    else if (nz_r[0] && nz_r[1] && nn_r[2]) orient = OR_NEG_Z;
    else                                    orient = OR_NONE;
  end

  assign dl_sum     = {1'b0, elapsed_r} + {1'b0, timeout_r};
  assign restart_dl = (dl_sum > T_MAX) ? {TIME_W{1'b1}} : dl_sum[TIME_W-1:0];
  assign still_end  = {1'b0, still_start_r}
                    + (lenient_r ? {1'b0, STILL_TIME_LENIENT} : {1'b0, STILL_TIME_NORMAL});

  always_comb begin
    still_new    = still_r;
    start_new    = still_start_r;
    deadline_new = deadline_r;
    fin_still    = 1'b0;
    if (all_below_r) begin
      if (!still_r) begin
        still_new    = 1'b1;
        start_new    = elapsed_r;
        deadline_new = restart_dl;
      end else if ({1'b0, elapsed_r} > still_end) begin
        fin_still = 1'b1;
      end
    end else if (any_above_r) begin
      still_new = 1'b0;
    end
    past_dl = elapsed_r > deadline_new;
    ot_next = {1'b0, ot_cnt_r} + 1'b1;
    fin_to  = !fin_still && past_dl && (ot_next > OT_LIM);
    ot_new  = (!fin_still && past_dl && !fin_to) ? ot_next[CNT_W-1:0] : ot_cnt_r;
    fin     = fin_still || fin_to;
    if (fin_still)   status = STAT_DECIDED;
    else if (fin_to) status = STAT_TIMEOUT;
    else             status = still_new ? STAT_STILL : STAT_MOVING;
  end

  assign stat.out_busy = out_valid_r && !out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lenient_r <= 1'b0;
      thresh_r  <= THRESH_RST;
      tol_r     <= TOL_RST;
      grav_r    <= GRAVITY_RST;
      timeout_r <= TIMEOUT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LENIENT: lenient_r <= cfg_data[0];
        REG_THRESH:  thresh_r  <= cfg_data[15:0];
        REG_TOL:     tol_r     <= cfg_data[15:0];
        REG_GRAVITY: grav_r    <= cfg_data[15:0];
        REG_TIMEOUT: timeout_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // run state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        mean_r[i] <= '0;
        disp_r[i] <= '0;
      end
      elapsed_r     <= '0;
      still_start_r <= '0;
      deadline_r    <= TIMEOUT_RST;
      still_r       <= 1'b0;
      ot_cnt_r      <= '0;
    end else begin
      if (cmd.accept) begin
        elapsed_r <= (elapsed_sum > T_MAX) ? {TIME_W{1'b1}} : elapsed_sum[TIME_W-1:0];
      end
      if (cmd.ph_c) begin
        mean_r[cmd.axis] <= mean_new;
        disp_r[cmd.axis] <= disp_new;
      end
      if (cmd.decide) begin
        still_start_r <= start_new;
        if (fin) begin
          for (int i = 0; i < 3; i++) begin
            mean_r[i] <= '0;
            disp_r[i] <= '0;
          end
          still_r    <= 1'b0;
          ot_cnt_r   <= '0;
          deadline_r <= restart_dl;
        end else begin
          still_r    <= still_new;
          ot_cnt_r   <= ot_new;
          deadline_r <= deadline_new;
        end
      end
    end
  end

  // per item work
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      smp_r[0] <= in_accel_x;
      smp_r[1] <= in_accel_y;
      smp_r[2] <= in_accel_z;
      dlt_r    <= in_delta_us;
      wsat_r   <= (32'(in_delta_us) >= 32'(EMA_TIME_US));
      q_r      <= '0;
      all_below_r <= 1'b1;
      any_above_r <= 1'b0;
    end
    if (cmd.div_step) begin
      thr2_r <= 36'(thr) * 36'(thr);
      plo_r  <= 47'(dlt_r) * 47'(RCP_LO);
      phi_r  <= 47'(dlt_r) * 47'(RCP_HI);
      q_r    <= wsum[62:47];
    end
    if (cmd.ph_a) begin
      d_r <= d_nxt;
    end
    if (cmd.ph_b) begin
      mw_r <= 55'(d_r) * 55'($signed({1'b0, w}));
      sq_r <= 42'(e) * 42'(e);
      dd_r <= 57'(disp_r[cmd.axis]) * 57'(W_ONE - w);
    end
    if (cmd.ph_c) begin
      if (!(disp_new < 40'(thr2_r)))           all_below_r <= 1'b0;
      if (disp_new > 40'({thr2_r, 2'b00}))     any_above_r <= 1'b1;
      nz_r[cmd.axis] <= near_tol(mq, tq);
      np_r[cmd.axis] <= near_tol(mq - gq, tq);
      nn_r[cmd.axis] <= near_tol(mq + gq, tq);
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.decide) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.decide) begin
      out_status_r <= status;
      out_orient_r <= fin_still ? orient : OR_NONE;
      for (int i = 0; i < 3; i++) begin
        out_mean_r[i] <= mean_r[i][34:16];
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_orientation = out_orient_r;
  assign out_mean_x      = out_mean_r[0];
  assign out_mean_y      = out_mean_r[1];
  assign out_mean_z      = out_mean_r[2];

  a_ot_bound: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, ot_cnt_r} <= OT_LIM)
    else $error("overtime count above limit");
  a_orient_none: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_status_r != STAT_DECIDED |-> out_orient_r == OR_NONE)
    else $error("orientation set without decision");
  a_elapsed_mono: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.accept |=> elapsed_r >= $past(elapsed_r))
    else $error("elapsed time went backward");

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import asod_pkg::*;

  typedef struct packed {
    logic signed [ACC_W-1:0] ax;
    logic signed [ACC_W-1:0] ay;
    logic signed [ACC_W-1:0] az;
    logic [DELTA_W-1:0]      dt;
  } accel_sample_t;

  typedef struct packed {
    logic [1:0]              status;
    logic [2:0]              orient;
    logic signed [ACC_W-1:0] mx;
    logic signed [ACC_W-1:0] my;
    logic signed [ACC_W-1:0] mz;
  } detect_result_t;

  localparam longint MAX40 = 64'hFF_FFFF_FFFF;
  localparam longint Q_ONE = 65536;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int SETTLE_CYCLES = 40;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  asod_in_if  in_ch();
  asod_out_if out_ch();
  asod_cfg_if cfg_ch();

  accel_still_orientation_detect_core DUT (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );

  always #1 clk = ~clk;

  // register shadow
  logic              lenient_q = 1'b0;
  logic [15:0]       thresh_q  = THRESH_RST;
  logic [15:0]       tol_q     = TOL_RST;
  logic [15:0]       gravity_q = GRAVITY_RST;
  logic [TIME_W-1:0] timeout_q = TIMEOUT_RST;

  // detector state
  longint mean_q16[3] = '{0, 0, 0};
  longint disp_sq[3]  = '{0, 0, 0};
  longint elapsed_us  = 0;
  longint still_start = 0;
  bit     still_on    = 1'b0;
  longint deadline_us = longint'(TIMEOUT_RST);
  longint overtime_n  = 0;

  accel_sample_t  pending_samples[$];
  detect_result_t expected_results[$];
  int mismatches = 0;
  int results_seen = 0;
  int status_seen[4] = '{0, 0, 0, 0};
  int orient_seen[7] = '{0, 0, 0, 0, 0, 0, 0};
  int cycles = 0;

  function automatic longint sat40(longint v);
    return (v > MAX40) ? MAX40 : v;
  endfunction

  function automatic bit near_g(longint m, longint target);
    longint diff;
    diff = m - target * Q_ONE;
    if (diff < 0) diff = -diff;
    return diff < longint'(tol_q) * Q_ONE;
  endfunction

  function automatic logic [2:0] pick_orientation();
    logic [2:0] codes[6];
    int sx[6], sy[6], sz[6];
    longint g;
    codes = '{OR_POS_X, OR_NEG_X, OR_POS_Y, OR_NEG_Y, OR_POS_Z, OR_NEG_Z};
    sx = '{1, -1, 0, 0, 0, 0};
    sy = '{0, 0, 1, -1, 0, 0};
    sz = '{0, 0, 0, 0, 1, -1};
    g = longint'(gravity_q);
    for (int k = 0; k < 6; k++) begin
      if (near_g(mean_q16[0], g * sx[k]) && near_g(mean_q16[1], g * sy[k]) &&
          near_g(mean_q16[2], g * sz[k]))
        return codes[k];
    end
    return OR_NONE;
  endfunction

  function automatic void restart_detector();
    for (int i = 0; i < 3; i++) begin
      mean_q16[i] = 0;
      disp_sq[i] = 0;
    end
    still_on = 1'b0;
    overtime_n = 0;
    deadline_us = sat40(elapsed_us + longint'(timeout_q));
  endfunction

  function automatic detect_result_t step_detector(accel_sample_t s);
    detect_result_t r;
    longint w, thr, thr2, still_t, x, d, e, sq;
    longint a[3];
    bit all_below, any_above, done;
    all_below = 1'b1;
    any_above = 1'b0;
    done = 1'b0;
    a = '{longint'(s.ax), longint'(s.ay), longint'(s.az)};
    w = (longint'(s.dt) * Q_ONE) / EMA_TIME_US_DEF;
    if (w > Q_ONE) w = Q_ONE;
    thr = longint'(thresh_q) * (lenient_q ? 3 : 1);
    thr2 = thr * thr;
    still_t = lenient_q ? longint'(STILL_TIME_LENIENT) : longint'(STILL_TIME_NORMAL);
    elapsed_us = sat40(elapsed_us + longint'(s.dt));
    for (int i = 0; i < 3; i++) begin
      x = a[i] * Q_ONE;
      d = x - mean_q16[i];
      e = d >>> 16;
      sq = e * e;
      mean_q16[i] += (d * w) >>> 16;
      disp_sq[i] = (disp_sq[i] * (Q_ONE - w)) >>> 16;
      if (sq > thr2 * 8) sq = thr2 * 8;
      if (sq > disp_sq[i]) disp_sq[i] = sq;
      if (!(disp_sq[i] < thr2)) all_below = 1'b0;
      if (disp_sq[i] > thr2 * 4) any_above = 1'b1;
    end
    if (all_below) begin
      if (!still_on) begin
        still_on = 1'b1;
        still_start = elapsed_us;
        deadline_us = sat40(elapsed_us + longint'(timeout_q));
      end else if (elapsed_us > still_start + still_t) begin
        done = 1'b1;
      end
    end else if (any_above) begin
      still_on = 1'b0;
    end
    r.orient = OR_NONE;
    if (done) begin
      r.status = STAT_DECIDED;
      r.orient = pick_orientation();
    end else begin
      r.status = still_on ? STAT_STILL : STAT_MOVING;
      if (elapsed_us > deadline_us) begin
        if (overtime_n + 1 > OVERTIME_LIMIT_DEF) begin
          r.status = STAT_TIMEOUT;
          done = 1'b1;
        end else begin
          overtime_n++;
        end
      end
    end
    r.mx = ACC_W'(mean_q16[0] >>> 16);
    r.my = ACC_W'(mean_q16[1] >>> 16);
    r.mz = ACC_W'(mean_q16[2] >>> 16);
    if (done) restart_detector();
    return r;
  endfunction

  task automatic report_mismatch(string field, longint got, longint want);
    $display("MISMATCH result %0d %s: got %0d expected %0d", results_seen, field, got, want);
    mismatches++;
  endtask

  // register writes tracked on accept
  always @(posedge clk) begin
    if (rst_n && cfg_ch.valid && cfg_ch.ready) begin
      case (cfg_ch.index)
        REG_LENIENT: lenient_q <= cfg_ch.data[0];
        REG_THRESH:  thresh_q <= cfg_ch.data[15:0];
        REG_TOL:     tol_q <= cfg_ch.data[15:0];
        REG_GRAVITY: gravity_q <= cfg_ch.data[15:0];
        REG_TIMEOUT: timeout_q <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  // sample driver, bursts and gaps
  int burst_left = 4;
  int gap_left = 0;
  always @(posedge clk) begin
    if (rst_n && (!in_ch.valid || in_ch.ready)) begin
      if (gap_left > 0 || pending_samples.size() == 0) begin
        in_ch.valid <= 1'b0;
        if (gap_left > 0) gap_left <= gap_left - 1;
      end else begin
        accel_sample_t s;
        s = pending_samples.pop_front();
        in_ch.valid <= 1'b1;
        in_ch.accel_x <= s.ax;
        in_ch.accel_y <= s.ay;
        in_ch.accel_z <= s.az;
        in_ch.delta_us <= s.dt;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 24);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
        end else begin
          burst_left <= burst_left - 1;
        end
      end
    end
  end

  // predict on every accepted beat
  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready)
      expected_results.push_back(step_detector({in_ch.accel_x, in_ch.accel_y,
                                                in_ch.accel_z, in_ch.delta_us}));
  end

  // result monitor with its own stall pattern
  int stall_mode = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles % 97 == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: out_ch.ready <= 1'b1;
      1: out_ch.ready <= 1'($urandom_range(0, 1));
      2: out_ch.ready <= ($urandom_range(0, 3) == 0);
      default: out_ch.ready <= ($urandom_range(0, 7) != 0);
    endcase
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected beat", 1, 0);
      end else begin
        detect_result_t want;
        want = expected_results.pop_front();
        if (out_ch.status !== want.status)
          report_mismatch("status", out_ch.status, want.status);
        if (out_ch.orientation !== want.orient)
          report_mismatch("orientation", out_ch.orientation, want.orient);
        if (out_ch.mean_x !== want.mx) report_mismatch("mean_x", out_ch.mean_x, want.mx);
        if (out_ch.mean_y !== want.my) report_mismatch("mean_y", out_ch.mean_y, want.my);
        if (out_ch.mean_z !== want.mz) report_mismatch("mean_z", out_ch.mean_z, want.mz);
        status_seen[want.status]++;
        if (want.status == STAT_DECIDED) orient_seen[want.orient]++;
      end
      results_seen++;
    end
  end

  always @(posedge clk) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [TIME_W-1:0] value);
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic write_all(logic len, logic [15:0] thr, logic [15:0] tol, logic [15:0] g,
                           logic [TIME_W-1:0] tmo);
    write_reg(REG_LENIENT, {39'd0, len});
    write_reg(REG_THRESH, {24'd0, thr});
    write_reg(REG_TOL, {24'd0, tol});
    write_reg(REG_GRAVITY, {24'd0, g});
    write_reg(REG_TIMEOUT, tmo);
  endtask

  task automatic wait_idle();
    wait (pending_samples.size() == 0 && !in_ch.valid && expected_results.size() == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic signed [ACC_W-1:0] clamp_acc(longint v);
    if (v > 262143) return ACC_W'(262143);
    if (v < -262144) return ACC_W'(-262144);
    return ACC_W'(v);
  endfunction

  function automatic accel_sample_t noise_sample(int max_dt);
    accel_sample_t s;
    s.ax = ACC_W'($urandom);
    s.ay = ACC_W'($urandom);
    s.az = ACC_W'($urandom);
    s.dt = DELTA_W'($urandom_range(0, max_dt));
    return s;
  endfunction

  // one run of samples around an orientation, code 6 gives an arbitrary vector
  task automatic push_run(int k, int len, int noise, int dt_lo, int dt_hi);
    longint g, base[3], off;
    accel_sample_t s;
    g = longint'(gravity_q);
    base = '{0, 0, 0};
    if (k < 6) base[k / 2] = (k % 2) ? -g : g;
    else for (int i = 0; i < 3; i++) base[i] = longint'($urandom_range(0, 60000)) - 30000;
    for (int n = 0; n < len; n++) begin
      off = longint'($urandom_range(0, 2 * noise)) - noise;
      s.ax = clamp_acc(base[0] + off);
      off = longint'($urandom_range(0, 2 * noise)) - noise;
      s.ay = clamp_acc(base[1] + off);
      off = longint'($urandom_range(0, 2 * noise)) - noise;
      s.az = clamp_acc(base[2] + off);
      s.dt = DELTA_W'($urandom_range(dt_lo, dt_hi));
      pending_samples.push_back(s);
    end
  endtask

  task automatic random_phase(int count);
    int r, pushed;
    pushed = 0;
    while (pushed < count) begin
      r = $urandom_range(0, 99);
      if (r < 15) begin
        pending_samples.push_back(noise_sample(1048575));
        pushed++;
      end else begin
        int len;
        len = (r < 60) ? $urandom_range(3, 8) : $urandom_range(5, 40);
        push_run($urandom_range(0, 6), len, $urandom_range(0, 300),
                 (r < 60) ? 600000 : 20000, 1048575);
        pushed += len;
      end
    end
  endtask

  initial begin
    accel_sample_t s;
    in_ch.valid = 1'b0;
    in_ch.accel_x = '0;
    in_ch.accel_y = '0;
    in_ch.accel_z = '0;
    in_ch.delta_us = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = REG_LENIENT;
    cfg_ch.data = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // directed: field extremes, then each orientation and none in three beats
    s = '{ax: 262143, ay: -262144, az: 262143, dt: 0};
    pending_samples.push_back(s);
    s = '{ax: -262144, ay: 262143, az: -262144, dt: 1048575};
    pending_samples.push_back(s);
    s = '{ax: 0, ay: 0, az: 0, dt: 1};
    pending_samples.push_back(s);
    wait_idle();
    write_all(1'b1, THRESH_RST, TOL_RST, GRAVITY_RST, TIMEOUT_RST);
    for (int k = 0; k < 7; k++) push_run(k, 3, 0, 1048575, 1048575);
    wait_idle();

    // default and extreme register settings, then random ones
    write_all(1'b0, THRESH_RST, TOL_RST, GRAVITY_RST, TIMEOUT_RST);
    random_phase(130);
    wait_idle();
    write_all(1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, TIME_W'(MAX40));
    random_phase(110);
    wait_idle();
    write_all(1'b0, 16'd1, 16'd0, 16'd0, 40'd0);
    random_phase(110);
    wait_idle();
    for (int p = 0; p < 2; p++) begin
      write_all(1'($urandom_range(0, 1)), 16'($urandom_range(1, 2000)),
                16'($urandom_range(500, 20000)), 16'($urandom_range(5000, 20000)),
                TIME_W'($urandom_range(1000000, 100000000)));
      random_phase(130);
      wait_idle();
    end

    // zero threshold never goes still, so overtime runs out
    write_all(1'b0, 16'd0, TOL_RST, GRAVITY_RST, 40'd0);
    for (int n = 0; n < 1010; n++) pending_samples.push_back(noise_sample(5000));
    wait_idle();

    $display("%0d results checked: %0d moving, %0d still, %0d decided, %0d timeout",
             results_seen, status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
    $display("decisions by orientation +x -x +y -y +z -z none: %0d %0d %0d %0d %0d %0d %0d",
             orient_seen[0], orient_seen[1], orient_seen[2], orient_seen[3],
             orient_seen[4], orient_seen[5], orient_seen[6]);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

### filelist.f
design/asod_pkg.sv
design/asod_if.sv
design/asod_ctrl.sv
design/asod_dp.sv
design/accel_still_orientation_detect_core.sv
tb/sv/testbench.sv
